// ----- src/xor_checked_frame_receiver_defines.svh -----
// assertion macros for the xor checked frame receiver
// used by the top level, which supplies clk_i and rst_ni in scope
`ifndef XOR_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define XOR_CHECKED_FRAME_RECEIVER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define XCFR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xcfr: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define XCFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xcfr: next-cycle check failed");

`endif

// ----- src/xcfr_pkg.sv -----
// shared types and constants for the xor checked frame receiver
// no dependencies
`timescale 1ns / 1ps

package xcfr_pkg;

  localparam logic [7:0] SYNC_RESET   = 8'hAA;
  localparam int unsigned HEADER_BYTES = 3;
  localparam int unsigned MIN_FRAME    = 4;
  localparam int unsigned POS_W        = 9;
  localparam int unsigned POS_LIMIT    = 511;
  localparam int unsigned QDEPTH       = 4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_FRAME_ERR = 2'd2
  } frame_status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_transfer;
  } rx_item_t;

  typedef struct packed {
    item_kind_e    item_kind;
    logic [7:0]    payload_byte;
    logic [7:0]    payload_index;
    logic [7:0]    command;
    logic [7:0]    declared_length;
    frame_status_e frame_status;
  } res_item_t;

  // up to two result items written per accepted byte, first one first
  typedef struct packed {
    logic [1:0] count;
    res_item_t  first;
    res_item_t  second;
  } push_t;

  typedef struct packed {
    logic [2:0] level;
    logic       room_for_two;
  } q_stat_t;

endpackage

// ----- src/xcfr_stream_if.sv -----
// valid/ready channel carrying one payload per transfer
// payload type given per instance, no other dependencies
`timescale 1ns / 1ps

interface xcfr_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/xcfr_queue.sv -----
// four entry result queue, two writes and one read per cycle
// depends on xcfr_pkg
`timescale 1ns / 1ps

module xcfr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  xcfr_pkg::push_t  push_i,
  input  logic             pop_i,
  output xcfr_pkg::res_item_t head_o,
  output xcfr_pkg::q_stat_t   stat_o
);
  import xcfr_pkg::*;

  localparam int unsigned PtrW = $clog2(QDEPTH);

  res_item_t       mem_q [QDEPTH];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [2:0]      level_q, level_d;

  always_comb begin
    wp_d    = wp_q + PtrW'(push_i.count);
    rp_d    = rp_q + PtrW'(pop_i);
    level_d = level_q + 3'(push_i.count) - 3'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      level_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wp_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wp_q + PtrW'(1)] <= push_i.second;
    end
  end

  assign head_o              = mem_q[rp_q];
  assign stat_o.level        = level_q;
  assign stat_o.room_for_two = (level_q <= 3'(QDEPTH - 2));

endmodule

// ----- src/xor_checked_frame_receiver.sv -----
// xor checked frame receiver: sync, command, length, payload, xor checksum
// an accepted byte's results are registered in the result queue, which drives res_o
// throughput: one byte per cycle while res_o is ready and each byte gives at most one
//   result; a last byte that is also payload gives two, drained one per ready cycle
// reset: rst_ni async active low, clears frame state, queue, sync to 0xaa
`timescale 1ns / 1ps
`include "xor_checked_frame_receiver_defines.svh"

module xor_checked_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input logic           clk_i,
  input logic           rst_ni,
  xcfr_stream_if.sink   rx_i,
  xcfr_stream_if.source res_o,
  xcfr_stream_if.sink   cfg_i
);
  import xcfr_pkg::*;

  localparam logic [7:0]       MaxLen   = 8'(MAX_PAYLOAD);
  localparam logic [POS_W-1:0] PosLimit = POS_W'(POS_LIMIT);

  // configuration register
  logic [7:0] sync_q;

  // per-frame state, cleared after each status item
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       xor_q, xor_d;
  logic             sync_ok_q, sync_ok_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       len_q, len_d;
  logic             cs_match_q, cs_match_d;

  logic             rx_fire, rx_last, cfg_fire, res_fire;
  logic [7:0]       rx_byte;
  logic [POS_W-1:0] cs_pos;
  logic             is_payload;
  frame_status_e    verdict;
  res_item_t        pay_item, stat_item;
  push_t            push;
  q_stat_t          q_stat;
  res_item_t        head;

  assign rx_byte  = rx_i.payload.data_byte;
  assign rx_last  = rx_i.payload.end_of_transfer;
  assign rx_fire  = rx_i.valid && rx_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  // only accept a byte when both of its possible results fit in the queue
  assign rx_i.ready  = q_stat.room_for_two;
  assign cfg_i.ready = 1'b1;

  // header capture and running xor for this byte
  always_comb begin
    len_d      = (pos_q == POS_W'(2)) ? rx_byte : len_q;
    cmd_d      = (pos_q == POS_W'(1)) ? rx_byte : cmd_q;
    sync_ok_d  = (pos_q == '0) ? (rx_byte == sync_q) : sync_ok_q;
    // checksum sits straight after the payload
    cs_pos     = POS_W'(HEADER_BYTES) + POS_W'(len_d);
    is_payload = (pos_q > POS_W'(2)) && (pos_q < cs_pos) && sync_ok_q && (len_q <= MaxLen);
    cs_match_d = ((pos_q > POS_W'(2)) && (pos_q == cs_pos)) ? (rx_byte == xor_q) : cs_match_q;
    xor_d      = (pos_q < cs_pos) ? (xor_q ^ rx_byte) : xor_q;
    // byte count saturates, trailing bytes only move the count
    pos_d      = (pos_q == PosLimit) ? pos_q : pos_q + POS_W'(1);
  end

  // verdict, checks in priority order
  always_comb begin
    priority if (pos_d < POS_W'(MIN_FRAME)) begin
      verdict = ST_SHORT;
    end else if (!sync_ok_d) begin
      verdict = ST_FRAME_ERR;
    end else if ({1'b0, pos_d} < (10'(MIN_FRAME) + 10'(len_d))) begin
      verdict = ST_SHORT;
    end else if (len_d > MaxLen) begin
      verdict = ST_FRAME_ERR;
    end else if (!cs_match_d) begin
      verdict = ST_FRAME_ERR;
    end else begin
      verdict = ST_OK;
    end
  end

  always_comb begin
    pay_item                 = '0;
    pay_item.item_kind       = KIND_PAYLOAD;
    pay_item.payload_byte    = rx_byte;
    pay_item.payload_index   = 8'(pos_q - POS_W'(HEADER_BYTES));
    pay_item.frame_status    = ST_OK;

    stat_item                 = '0;
    stat_item.item_kind       = KIND_STATUS;
    stat_item.command         = cmd_d;
    stat_item.declared_length = len_d;
    stat_item.frame_status    = verdict;

    // payload item goes out before the status item of the same byte
    push.first  = is_payload ? pay_item : stat_item;
    push.second = stat_item;
    push.count  = rx_fire ? (2'(is_payload) + 2'(rx_last)) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q     <= SYNC_RESET;
      pos_q      <= '0;
      xor_q      <= '0;
      sync_ok_q  <= 1'b0;
      cmd_q      <= '0;
      len_q      <= '0;
      cs_match_q <= 1'b0;
    end else begin
      if (cfg_fire) begin
        sync_q <= cfg_i.payload;
      end
      if (rx_fire) begin
        if (rx_last) begin
          // end of transfer, back to a clean frame
          pos_q      <= '0;
          xor_q      <= '0;
          sync_ok_q  <= 1'b0;
          cmd_q      <= '0;
          len_q      <= '0;
          cs_match_q <= 1'b0;
        end else begin
          pos_q      <= pos_d;
          xor_q      <= xor_d;
          sync_ok_q  <= sync_ok_d;
          cmd_q      <= cmd_d;
          len_q      <= len_d;
          cs_match_q <= cs_match_d;
        end
      end
    end
  end

  // result queue doubles as the output register
  xcfr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (res_fire),
    .head_o (head),
    .stat_o (q_stat)
  );

  assign res_o.valid   = (q_stat.level != 3'd0);
  assign res_o.payload = head;
  assign res_fire      = res_o.valid && res_o.ready;

  // checks
  `XCFR_ASSERT_NEXT(a_clear_after_last, rx_fire && rx_last, pos_q == '0 && xor_q == '0)
  `XCFR_ASSERT_NEXT(a_pos_counts, rx_fire && !rx_last && pos_q != PosLimit, pos_q == $past(pos_q) + POS_W'(1))
  `XCFR_ASSERT_SAME(a_level_bound, 1'b1, q_stat.level <= 3'(QDEPTH))
  `XCFR_ASSERT_SAME(a_payload_clean, res_o.valid && res_o.payload.item_kind == KIND_PAYLOAD, res_o.payload.frame_status == ST_OK && res_o.payload.command == '0)

endmodule
